// ===== design/ezr_pkg.sv =====
package ezr_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int OUT_BITS = 16;
   localparam int FRAC = OUT_BITS - 2;
   localparam int IFRAC = 30;
   localparam int STEPS = 30;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [OUT_BITS-1:0] entry_type;
   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [31:0] turn_type;

   typedef struct packed {
      angle_type angle_z;
      angle_type angle_x;
      angle_type angle_y;
   } req_type;

   typedef struct packed {
      entry_type m00;
      entry_type m01;
      entry_type m02;
      entry_type m10;
      entry_type m11;
      entry_type m12;
      entry_type m20;
      entry_type m21;
      entry_type m22;
   } rsp_type;

   // atan(2^-i) in units of 2^32 per turn
   function automatic turn_type atan_turn(input logic [4:0] i);
      case (i)
         5'd0: atan_turn = 32'sd536870912;
         5'd1: atan_turn = 32'sd316933406;
         5'd2: atan_turn = 32'sd167458907;
         5'd3: atan_turn = 32'sd85004756;
         5'd4: atan_turn = 32'sd42667331;
         5'd5: atan_turn = 32'sd21354465;
         5'd6: atan_turn = 32'sd10679838;
         5'd7: atan_turn = 32'sd5340245;
         5'd8: atan_turn = 32'sd2670163;
         5'd9: atan_turn = 32'sd1335087;
         5'd10: atan_turn = 32'sd667544;
         5'd11: atan_turn = 32'sd333772;
         5'd12: atan_turn = 32'sd166886;
         5'd13: atan_turn = 32'sd83443;
         5'd14: atan_turn = 32'sd41722;
         5'd15: atan_turn = 32'sd20861;
         5'd16: atan_turn = 32'sd10430;
         5'd17: atan_turn = 32'sd5215;
         5'd18: atan_turn = 32'sd2608;
         5'd19: atan_turn = 32'sd1304;
         5'd20: atan_turn = 32'sd652;
         5'd21: atan_turn = 32'sd326;
         5'd22: atan_turn = 32'sd163;
         5'd23: atan_turn = 32'sd81;
         5'd24: atan_turn = 32'sd41;
         5'd25: atan_turn = 32'sd20;
         5'd26: atan_turn = 32'sd10;
         5'd27: atan_turn = 32'sd5;
         5'd28: atan_turn = 32'sd3;
         5'd29: atan_turn = 32'sd1;
         default: atan_turn = 32'sd0;
      endcase
   endfunction

   // clamp to +-one in Q2.FRAC
   function automatic entry_type clamp_one(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] one;
      one = CW'(1) <<< FRAC;
      if (v > one) clamp_one = OUT_BITS'(one);
      else if (v < -one) clamp_one = OUT_BITS'(-one);
      else clamp_one = OUT_BITS'(v);
   endfunction

   // rounded product back to Q2.FRAC, round half up
   function automatic logic signed [OUT_BITS+1:0] mulr(input entry_type a, input entry_type b);
      logic signed [2*OUT_BITS-1:0] p;
      p = a * b;
      p = p + (2*OUT_BITS)'(1 <<< (FRAC - 1));
      mulr = (OUT_BITS+2)'(p >>> FRAC);
   endfunction

endpackage

// ===== design/ezr_stream_if.sv =====
interface ezr_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== design/euler_zxy_to_rotation_matrix.sv =====
// channel | dir | payload
// req     | in  | angle_z, angle_x, angle_y (signed 16, 65536 per turn)
// rsp     | out | m00..m22 (signed Q2.14)
// one word per cycle while the output is not stalled; stages: fold, 30 cordic
// steps (one per stage, three angles in parallel), rounding, two multiply stages,
// then sum and clamp into the output register.
// reset clears every stage valid bit; payload registers are not reset.
// the whole pipe advances when its last stage is empty or being taken, so a
// stall freezes every word in place with nothing lost or repeated.
module euler_zxy_to_rotation_matrix (
   input logic clock,
   input logic reset,
   ezr_stream_if.sink req,
   ezr_stream_if.source rsp
);
   import ezr_pkg::*;

   localparam int NS = STEPS + 5;

   logic advance;
   logic [NS-1:0] vld_ff, vld_in;

   // cordic state per angle
   cw_type x_ff [3][STEPS+1], x_in [3][STEPS+1];
   cw_type y_ff [3][STEPS+1], y_in [3][STEPS+1];
   turn_type z_ff [3][STEPS+1], z_in [3][STEPS+1];
   logic neg_ff [3][STEPS+1], neg_in [3][STEPS+1];

   entry_type s_ff [3], s_in [3], c_ff [3], c_in [3];

   // first product stage
   logic signed [OUT_BITS+1:0] p_ff [10], p_in [10];
   entry_type sx1_ff, sx1_in, sz1_ff, sz1_in, cz1_ff, cz1_in;
   // second stage
   logic signed [OUT_BITS+1:0] q_ff [9], q_in [9];
   rsp_type out_ff, out_in;

   assign advance = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = vld_ff[NS-1];
   assign rsp.payload = out_ff;

   always_comb begin
      angle_type a [3];
      turn_type t;
      a[0] = req.payload.angle_z;
      a[1] = req.payload.angle_x;
      a[2] = req.payload.angle_y;
      vld_in = {vld_ff[NS-2:0], req.valid};
      for (int k = 0; k < 3; k++) begin
         // quadrant fold at entry
         t = turn_type'({a[k], {(32-ANGLE_BITS){1'b0}}});
         neg_in[k][0] = 1'b0;
         z_in[k][0] = t;
         if (t > 32'sh4000_0000) begin
            z_in[k][0] = t - 32'sh8000_0000;
            neg_in[k][0] = 1'b1;
         end else if (t < -32'sh4000_0000) begin
            z_in[k][0] = t + 32'sh8000_0000;
            neg_in[k][0] = 1'b1;
         end
         x_in[k][0] = CORDIC_GAIN;
         y_in[k][0] = '0;
         for (int i = 0; i < STEPS; i++) begin
            neg_in[k][i+1] = neg_ff[k][i];
            if (!z_ff[k][i][31]) begin
               x_in[k][i+1] = x_ff[k][i] - (y_ff[k][i] >>> i);
               y_in[k][i+1] = y_ff[k][i] + (x_ff[k][i] >>> i);
               z_in[k][i+1] = z_ff[k][i] - atan_turn(5'(i));
            end else begin
               x_in[k][i+1] = x_ff[k][i] + (y_ff[k][i] >>> i);
               y_in[k][i+1] = y_ff[k][i] - (x_ff[k][i] >>> i);
               z_in[k][i+1] = z_ff[k][i] + atan_turn(5'(i));
            end
         end
      end
   end

   always_comb begin
      cw_type xr, yr;
      cw_type half;
      half = CW'(1) <<< (IFRAC - FRAC - 1);
      for (int k = 0; k < 3; k++) begin
         xr = neg_ff[k][STEPS] ? -x_ff[k][STEPS] : x_ff[k][STEPS];
         yr = neg_ff[k][STEPS] ? -y_ff[k][STEPS] : y_ff[k][STEPS];
         c_in[k] = clamp_one((xr + half) >>> (IFRAC - FRAC));
         s_in[k] = clamp_one((yr + half) >>> (IFRAC - FRAC));
      end
   end

   // index 0 z, 1 x, 2 y
   always_comb begin
      p_in[0] = mulr(c_ff[0], c_ff[2]);  // cz*cy
      p_in[1] = mulr(s_ff[1], s_ff[2]);  // sx*sy
      p_in[2] = mulr(s_ff[0], c_ff[1]);  // sz*cx
      p_in[3] = mulr(c_ff[0], s_ff[2]);  // cz*sy
      p_in[4] = mulr(s_ff[1], c_ff[2]);  // sx*cy
      p_in[5] = mulr(s_ff[0], c_ff[2]);  // sz*cy
      p_in[6] = mulr(c_ff[0], c_ff[1]);  // cz*cx
      p_in[7] = mulr(s_ff[0], s_ff[2]);  // sz*sy
      p_in[8] = mulr(c_ff[1], s_ff[2]);  // cx*sy
      p_in[9] = mulr(c_ff[1], c_ff[2]);  // cx*cy
      sx1_in = s_ff[1];
      sz1_in = s_ff[0];
      cz1_in = c_ff[0];
      // second stage: three-factor products, rest passes
      q_in[0] = mulr(sz1_ff, OUT_BITS'(p_ff[1]));
      q_in[1] = mulr(sz1_ff, OUT_BITS'(p_ff[4]));
      q_in[2] = mulr(cz1_ff, OUT_BITS'(p_ff[1]));
      q_in[3] = mulr(cz1_ff, OUT_BITS'(p_ff[4]));
      q_in[4] = p_ff[0];
      q_in[5] = p_ff[3];
      q_in[6] = p_ff[5];
      q_in[7] = p_ff[7];
      q_in[8] = '0;
   end

   // p_ff 2,6,8,9 and sx need one extra stage of delay
   logic signed [OUT_BITS+1:0] d_ff [4], d_in [4];
   entry_type sx2_ff, sx2_in;
   always_comb begin
      d_in[0] = p_ff[2];
      d_in[1] = p_ff[6];
      d_in[2] = p_ff[8];
      d_in[3] = p_ff[9];
      sx2_in = sx1_ff;
      out_in.m00 = clamp_one(CW'(q_ff[4]) - CW'(q_ff[0]));
      out_in.m01 = clamp_one(-CW'(d_ff[0]));
      out_in.m02 = clamp_one(CW'(q_ff[5]) + CW'(q_ff[1]));
      out_in.m10 = clamp_one(CW'(q_ff[6]) + CW'(q_ff[2]));
      out_in.m11 = clamp_one(CW'(d_ff[1]));
      out_in.m12 = clamp_one(CW'(q_ff[7]) - CW'(q_ff[3]));
      out_in.m20 = clamp_one(-CW'(d_ff[2]));
      out_in.m21 = sx2_ff;
      out_in.m22 = clamp_one(CW'(d_ff[3]) + CW'(q_ff[8]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         neg_ff <= neg_in;
         s_ff <= s_in;
         c_ff <= c_in;
         p_ff <= p_in;
         sx1_ff <= sx1_in;
         sz1_ff <= sz1_in;
         cz1_ff <= cz1_in;
         q_ff <= q_in;
         d_ff <= d_in;
         sx2_ff <= sx2_in;
         out_ff <= out_in;
      end
   end

   // a stalled result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed under stall");
   // input is taken whenever the output side is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipe stalled with empty output");
   // an accepted word moves into the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted word lost");
endmodule

// ===== sim/ezr_checker.sv =====
module ezr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input ezr_pkg::req_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input ezr_pkg::rsp_type rsp_payload,
   output int fail_count,
   output int pending
);
   import ezr_pkg::*;

   localparam longint ONE = longint'(1) << FRAC;

   longint arctan_turn [STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1};

   rsp_type matrix_q[$];

   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint sat_unit(input longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return round_half_up(a * b, FRAC);
   endfunction

   // cordic sine and cosine of a binary angle, rounded to q2.14
   function automatic void angle_sin_cos(input angle_type a, output longint s,
                                         output longint c);
      logic signed [31:0] turn;
      longint z, x, y, nx;
      bit flip;
      turn = {a, {(32 - ANGLE_BITS){1'b0}}};
      z = longint'(turn);
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > (longint'(1) << 30)) begin
         z -= longint'(1) << 31;
         flip = 1;
      end else if (z < -(longint'(1) << 30)) begin
         z += longint'(1) << 31;
         flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan_turn[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan_turn[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = sat_unit(round_half_up(x, IFRAC - FRAC));
      s = sat_unit(round_half_up(y, IFRAC - FRAC));
   endfunction

   function automatic rsp_type rotation_of(input req_type r);
      longint sz, cz, sx, cx, sy, cy;
      rsp_type m;
      angle_sin_cos(r.angle_z, sz, cz);
      angle_sin_cos(r.angle_x, sx, cx);
      angle_sin_cos(r.angle_y, sy, cy);
      m.m00 = entry_type'(sat_unit(qmul(cz, cy) - qmul(sz, qmul(sx, sy))));
      m.m01 = entry_type'(sat_unit(-qmul(sz, cx)));
      m.m02 = entry_type'(sat_unit(qmul(cz, sy) + qmul(sz, qmul(sx, cy))));
      m.m10 = entry_type'(sat_unit(qmul(sz, cy) + qmul(cz, qmul(sx, sy))));
      m.m11 = entry_type'(sat_unit(qmul(cz, cx)));
      m.m12 = entry_type'(sat_unit(qmul(sz, sy) - qmul(cz, qmul(sx, cy))));
      m.m20 = entry_type'(sat_unit(-qmul(cx, sy)));
      m.m21 = entry_type'(sat_unit(sx));
      m.m22 = entry_type'(sat_unit(qmul(cx, cy)));
      return m;
   endfunction

   task automatic check_entry(input string name, input entry_type exp_v, input entry_type act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending = matrix_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) matrix_q.push_back(rotation_of(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (matrix_q.size() == 0) begin
               $error("unexpected word m00=%0d", rsp_payload.m00);
               fail_count++;
            end else begin
               want = matrix_q.pop_front();
               check_entry("m00", want.m00, rsp_payload.m00);
               check_entry("m01", want.m01, rsp_payload.m01);
               check_entry("m02", want.m02, rsp_payload.m02);
               check_entry("m10", want.m10, rsp_payload.m10);
               check_entry("m11", want.m11, rsp_payload.m11);
               check_entry("m12", want.m12, rsp_payload.m12);
               check_entry("m20", want.m20, rsp_payload.m20);
               check_entry("m21", want.m21, rsp_payload.m21);
               check_entry("m22", want.m22, rsp_payload.m22);
            end
         end
      end
   end

endmodule

// ===== sim/tb.sv =====
module tb;
   import ezr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int ITEMS_PER_PHASE = 175;

   logic clock;
   logic reset;
   int cycle_count;
   int fail_count;
   int pending;

   // idle and stall percentages for the current phase
   int send_idle_pct;
   int recv_stall_pct;
   // request for one long receiver hold-off
   bit long_hold;

   ezr_stream_if #(.payload_type(req_type)) req_if ();
   ezr_stream_if #(.payload_type(rsp_type)) rsp_if ();

   euler_zxy_to_rotation_matrix u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   ezr_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_payload(rsp_if.payload),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // timeout watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall plus one long hold-off on request
   initial rsp_if.ready = 0;
   always @(posedge clock) begin
      int hold_left;
      bit held;
      if (reset) begin
         rsp_if.ready <= 0;
      end else begin
         if (long_hold && !held) begin
            held = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one word, with random idle cycles in front of it
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.payload <= w;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // angles near the quadrant fold points and extremes, else uniform
   function automatic angle_type pick_angle();
      angle_type pts [10] = '{0, 16384, -16384, -32768, 32767, 1, -1, 8192, 16385, -16385};
      if ($urandom_range(3) == 0)
         return pts[$urandom_range(9)] + angle_type'($signed($urandom_range(4)) - 2);
      return angle_type'($urandom);
   endfunction

   task automatic send_angles(input angle_type z, input angle_type x, input angle_type y);
      req_type w;
      w.angle_z = z;
      w.angle_x = x;
      w.angle_y = y;
      send_word(w);
   endtask

   initial begin
      angle_type pts [10] = '{0, 16384, -16384, -32768, 32767, 1, -1, 8192, 16385, -16385};
      req_if.valid <= 0;
      req_if.payload <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold = 0;
      reset <= 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: z and x alone at the extremes and the quarter-turn fold edges, y alone at two of them, then all three
      foreach (pts[i]) send_angles(pts[i], 0, 0);
      foreach (pts[i]) send_angles(0, pts[i], 0);
      send_angles(0, 0, 16384);
      send_angles(0, 0, -32768);
      send_angles(-32768, -32768, -32768);
      send_angles(32767, 32767, 32767);
      send_angles(16384, 16384, 16384);

      // random phases: no idling with long hold-off, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               long_hold = 1;
            end
            1: begin
               send_idle_pct = 84;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 84;
            end
            default: begin
               send_idle_pct = 35;
               recv_stall_pct = 35;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_if.valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ezr_pkg.sv
design/ezr_stream_if.sv
design/euler_zxy_to_rotation_matrix.sv
sim/ezr_checker.sv
sim/tb.sv
